/* rtl/ias_pkg.sv */
// ----------------------------------------------------------------------------
// ias_pkg
// Shared types and codes for the indexed array stack: operation and status
// codes, field widths and the command that is broadcast along the cell row.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_op OP_PUSH   = 3'd0;
    localparam t_op OP_POP    = 3'd1;
    localparam t_op OP_INSERT = 3'd2;
    localparam t_op OP_REMOVE = 3'd3;
    localparam t_op OP_SWAP   = 3'd4;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    // Command seen by every cell in the cycle a beat is accepted.
    typedef struct packed {
        logic  apply;
        t_op   op;
        t_word word;
    } t_cell_cmd;

endpackage

/* rtl/ias_in_if.sv */
// ----------------------------------------------------------------------------
// ias_in_if
// Request channel: operation, position and word, with valid/ready.
// ----------------------------------------------------------------------------
interface ias_in_if;

    logic                                valid;
    logic                                ready;
    logic [ias_pkg::OP_W-1:0]            operation;
    logic [ias_pkg::POS_W-1:0]           position;
    logic signed [ias_pkg::WORD_W-1:0]   word_in;

    modport source (output valid, output operation, output position, output word_in,
                    input ready);
    modport sink   (input valid, input operation, input position, input word_in,
                    output ready);

endinterface

/* rtl/ias_out_if.sv */
// ----------------------------------------------------------------------------
// ias_out_if
// Response channel: removed word, count and status, with valid/ready.
// ----------------------------------------------------------------------------
interface ias_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [ias_pkg::WORD_W-1:0]   word_out;
    logic [ias_pkg::COUNT_W-1:0]         count;
    logic [ias_pkg::STAT_W-1:0]          status;

    modport source (output valid, output word_out, output count, output status,
                    input ready);
    modport sink   (input valid, input word_out, input count, input status,
                    output ready);

endinterface

/* rtl/ias_cell.sv */
// ----------------------------------------------------------------------------
// ias_cell
// One storage cell of the list. It holds the word at a fixed index and, on
// an applied command, takes its new word from the request, from either
// neighbor or from the last word of the list.
// ----------------------------------------------------------------------------
module ias_cell #(
    parameter int IDX_W = 7,
    parameter int INDEX = 0
) (
    input  logic               i_clk,
    input  ias_pkg::t_cell_cmd i_cmd,
    input  logic [IDX_W-1:0]   i_pos,
    input  logic [IDX_W-1:0]   i_fill,
    input  ias_pkg::t_word     i_left,
    input  ias_pkg::t_word     i_right,
    input  ias_pkg::t_word     i_last,
    output ias_pkg::t_word     o_word
);

    localparam logic [IDX_W-1:0] K = IDX_W'(INDEX);

    ias_pkg::t_word r_word;
    ias_pkg::t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_cmd.apply) begin
            case (i_cmd.op)
                ias_pkg::OP_PUSH: begin
                    if (K == i_fill) n_word = i_cmd.word;
                end
                ias_pkg::OP_INSERT: begin
                    if (K == i_pos) begin
                        n_word = i_cmd.word;
                    end else if (K > i_pos && K <= i_fill) begin
                        n_word = i_left;
                    end
                end
                ias_pkg::OP_REMOVE: begin
                    // Cells past the end pick up stale data; they are never read.
                    if (K >= i_pos) n_word = i_right;
                end
                ias_pkg::OP_SWAP: begin
                    if (K == i_pos) n_word = i_last;
                end
                default: n_word = r_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

/* rtl/indexed_array_stack.sv */
// ----------------------------------------------------------------------------
// indexed_array_stack
// Bounded ordered list of 32-bit words with push, pop, insert, remove and
// swap remove, held in a row of cells that all shift in the same cycle.
// ----------------------------------------------------------------------------
// The response beat is registered, valid in the cycle after the request beat.
// Throughput: one request per cycle while each response is taken; every
// cell moves at once, so an insert or remove at any index is as fast as a push.
// The response register frees the request side whenever it is taken.
// Reset clears the count and the response valid; stored words stay undefined
// until written and are never read before that.
module indexed_array_stack #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ias_in_if.sink        i_req,
    ias_out_if.source     o_rsp
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (FILL_W > ias_pkg::POS_W) ? FILL_W : ias_pkg::POS_W;
    localparam logic [IDX_W-1:0] CAP_C = IDX_W'(CAPACITY);

    logic [FILL_W-1:0]        r_fill;
    logic [FILL_W-1:0]        n_fill;
    logic                     r_out_valid;
    ias_pkg::t_word           r_word_out;
    ias_pkg::t_word           n_word_out;
    logic [ias_pkg::COUNT_W-1:0] r_count;
    ias_pkg::t_status         r_status;
    ias_pkg::t_status         n_status;

    logic                     w_accept;
    logic                     w_ok;
    logic [IDX_W-1:0]         w_pos;
    logic [IDX_W-1:0]         w_fill;
    ias_pkg::t_word           w_rd_pos;
    ias_pkg::t_word           w_rd_last;
    ias_pkg::t_cell_cmd       w_cmd;
    ias_pkg::t_word           w_cell [CAPACITY];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_pos       = IDX_W'(i_req.position);
    assign w_fill      = IDX_W'(r_fill);

    // Word at the requested index and the last word, gathered from the row.
    always_comb begin
        w_rd_pos  = '0;
        w_rd_last = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_pos == IDX_W'(k))      w_rd_pos  = w_rd_pos  | w_cell[k];
            if (w_fill == IDX_W'(k + 1)) w_rd_last = w_rd_last | w_cell[k];
        end
    end

    always_comb begin
        w_ok       = 1'b0;
        n_status   = ias_pkg::ST_RANGE;
        n_word_out = '0;
        n_fill     = r_fill;
        case (i_req.operation)
            ias_pkg::OP_PUSH: begin
                if (w_fill >= CAP_C) begin
                    n_status = ias_pkg::ST_FULL;
                end else begin
                    w_ok = 1'b1;
                end
            end
            ias_pkg::OP_POP: begin
                if (r_fill != '0) begin
                    w_ok       = 1'b1;
                    n_word_out = w_rd_last;
                end
            end
            ias_pkg::OP_INSERT: begin
                // The range check takes priority over the full check.
                if (w_pos > w_fill) begin
                    n_status = ias_pkg::ST_RANGE;
                end else if (w_fill >= CAP_C) begin
                    n_status = ias_pkg::ST_FULL;
                end else begin
                    w_ok = 1'b1;
                end
            end
            ias_pkg::OP_REMOVE, ias_pkg::OP_SWAP: begin
                if (w_pos < w_fill) begin
                    w_ok       = 1'b1;
                    n_word_out = w_rd_pos;
                end
            end
            default: w_ok = 1'b0;
        endcase
        if (w_ok) begin
            n_status = ias_pkg::ST_DONE;
            if (i_req.operation == ias_pkg::OP_PUSH ||
                i_req.operation == ias_pkg::OP_INSERT) begin
                n_fill = r_fill + 1'b1;
            end else begin
                n_fill = r_fill - 1'b1;
            end
        end
    end

    assign w_cmd.apply = w_accept && w_ok;
    assign w_cmd.op    = i_req.operation;
    assign w_cmd.word  = $unsigned(i_req.word_in);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ias_pkg::t_word w_left;
        ias_pkg::t_word w_right;
        if (g == 0) begin : g_first
            assign w_left = w_cell[g];
        end else begin : g_mid
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_inner
            assign w_right = w_cell[g+1];
        end
        ias_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_pos),
            .i_fill  (w_fill),
            .i_left  (w_left),
            .i_right (w_right),
            .i_last  (w_rd_last),
            .o_word  (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word_out <= n_word_out;
            r_count    <= ias_pkg::COUNT_W'(n_fill);
            r_status   <= n_status;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.word_out = $signed(r_word_out);
    assign o_rsp.count    = r_count;
    assign o_rsp.status   = r_status;

    // The count never passes the capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IDX_W'(r_fill) <= CAP_C)
        else $error("fill count beyond capacity");

    // A failed beat never returns a word.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ias_pkg::ST_DONE |-> r_word_out == '0)
        else $error("failed beat carries a word");

    // A push into a list with room succeeds and grows the count by one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.operation == ias_pkg::OP_PUSH && w_fill < CAP_C
        |=> r_status == ias_pkg::ST_DONE && r_fill == $past(r_fill) + 1'b1)
        else $error("push with room did not grow the list");

    // A pop from an empty list reports a range error and leaves the count.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.operation == ias_pkg::OP_POP && r_fill == '0
        |=> r_status == ias_pkg::ST_RANGE && r_fill == '0)
        else $error("pop from empty list misreported");

endmodule
